>>> hdl/handle_compaction_table_assert.svh
// Assertion macros used by the handle compaction table checker.
`ifndef HANDLE_COMPACTION_TABLE_ASSERT_SVH
`define HANDLE_COMPACTION_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clock, quiet while reset is high.
`define HCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet while reset is high.
`define HCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/hct_pkg.sv
// Shared constants, codes and types for the handle compaction table.
`timescale 1ns / 1ps

package hct_pkg;

   localparam int PROGRAMS  = 1024;
   localparam int ENTRIES   = 32;

   localparam int SLOT_IN_W = 12;
   localparam int HANDLE_W  = 32;
   localparam int ID_W      = 7;
   localparam int STATUS_W  = 3;

   localparam int SLOT_W    = (PROGRAMS > 1) ? $clog2(PROGRAMS) : 1;
   localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W   = $clog2(ENTRIES + 1);
   localparam int STORE_AW  = SLOT_W + ENTRY_W;

   localparam int COUNT_DEPTH = PROGRAMS;
   localparam int STORE_DEPTH = 2 ** STORE_AW;

   localparam logic [ID_W-1:0]     ID_NONE     = {ID_W{1'b1}};
   localparam logic [HANDLE_W-1:0] HANDLE_NONE = {HANDLE_W{1'b1}};

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_RESOLVE  = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NEW       = 3'd0,
      STAT_EXISTING  = 3'd1,
      STAT_BAD_SLOT  = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_UNKNOWN   = 3'd4,
      STAT_NO_HANDLE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_COUNT,
      S_SEARCH,
      S_FETCH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [SLOT_IN_W-1:0] slot;
      logic [HANDLE_W-1:0]  handle;
      logic [ID_W-1:0]      cid;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      status_type          status;
   } res_type;

   typedef struct packed {
      logic               we;
      logic [SLOT_W-1:0]  waddr;
      logic [COUNT_W-1:0] wdata;
      logic [SLOT_W-1:0]  raddr;
   } cnt_port_type;

   typedef struct packed {
      logic                we;
      logic [STORE_AW-1:0] waddr;
      logic [HANDLE_W-1:0] wdata;
      logic [STORE_AW-1:0] raddr;
   } store_port_type;

endpackage

>>> hdl/handle_compaction_table.sv
// Top level of the handle compaction table: memories, sequencer and result register.
// Flow: an accepted item reads its slot's count in S_COUNT; register then compares stored
//   handles in S_SEARCH, resolve reads one in S_FETCH, and S_RESP hands the result on.
// One item at a time: the next beat is taken in the cycle after the result
//   enters the output register.
// Reset: synchronous, active high; afterwards a pass zeroes the count memory, one slot
//   per cycle, with req_ready low. The handle store is not cleared.
`timescale 1ns / 1ps

module handle_compaction_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [hct_pkg::SLOT_IN_W-1:0]       req_prog_slot,
   input  logic signed [hct_pkg::HANDLE_W-1:0] req_handle_value,
   input  logic signed [hct_pkg::ID_W-1:0]     req_compact_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hct_pkg::ID_W-1:0]     rsp_result_id,
   output logic signed [hct_pkg::HANDLE_W-1:0] rsp_resolved_handle,
   output logic [hct_pkg::STATUS_W-1:0]        rsp_status
);

   // request bundle into the sequencer
   hct_pkg::req_type             req;
   hct_pkg::res_type             res;
   logic                         res_valid;
   logic                         out_free;

   // memory ports: per-slot list length, and the handle lists themselves
   hct_pkg::cnt_port_type        cnt_port;
   logic [hct_pkg::COUNT_W-1:0]  cnt_rdata;
   hct_pkg::store_port_type      store_port;
   logic [hct_pkg::HANDLE_W-1:0] store_rdata;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   hct_pkg::res_type             rsp_ff;

   assign req.opcode = req_opcode;
   assign req.slot   = req_prog_slot;
   assign req.handle = req_handle_value;
   assign req.cid    = req_compact_id;

   // Entry count per slot: cleared by the sweep after reset, zeroed again by clear.
   hct_ram #(
      .WIDTH (hct_pkg::COUNT_W),
      .DEPTH (hct_pkg::COUNT_DEPTH)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_port.we),
      .waddr (cnt_port.waddr),
      .wdata (cnt_port.wdata),
      .raddr (cnt_port.raddr),
      .rdata (cnt_rdata)
   );

   // Handle store, addressed {slot, id}. Only handles of ids below the slot's count are used,
   // and each of those was written by the append that raised the count.
   hct_ram #(
      .WIDTH (hct_pkg::HANDLE_W),
      .DEPTH (hct_pkg::STORE_DEPTH)
   ) u_store_ram (
      .clock (clock),
      .we    (store_port.we),
      .waddr (store_port.waddr),
      .wdata (store_port.wdata),
      .raddr (store_port.raddr),
      .rdata (store_rdata)
   );

   // Sequencer: reads the count, walks the list one entry a cycle, appends or
   // fetches, and holds the result until the output register has room. All
   // memory writes finish before the next beat is taken, so no forwarding.
   hct_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .res_valid   (res_valid),
      .res         (res),
      .out_free    (out_free),
      .cnt_port    (cnt_port),
      .cnt_rdata   (cnt_rdata),
      .store_port  (store_port),
      .store_rdata (store_rdata)
   );

   // Output register parts the two sides: it is free when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_id       = rsp_ff.id;
   assign rsp_resolved_handle = rsp_ff.handle;
   assign rsp_status          = rsp_ff.status;

endmodule

>>> hdl/hct_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module hct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/hct_ctrl.sv
// Sequencer: count lookup, handle search, append, resolve and clearing pass.
`timescale 1ns / 1ps

module hct_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hct_pkg::req_type                   req,
   output logic                               res_valid,
   output hct_pkg::res_type                   res,
   input  logic                               out_free,
   output hct_pkg::cnt_port_type              cnt_port,
   input  logic [hct_pkg::COUNT_W-1:0]        cnt_rdata,
   output hct_pkg::store_port_type            store_port,
   input  logic [hct_pkg::HANDLE_W-1:0]       store_rdata
);

   hct_pkg::state_type                 state_ff, state_in;
   logic [1:0]                         op_ff;
   logic                               slot_ok_ff;
   logic [hct_pkg::SLOT_W-1:0]         slot_idx_ff;
   logic [hct_pkg::HANDLE_W-1:0]       handle_ff;
   logic [hct_pkg::ID_W-1:0]           cid_ff;
   logic [hct_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [hct_pkg::ENTRY_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [hct_pkg::SLOT_W-1:0]         clr_idx_ff, clr_idx_in;
   hct_pkg::res_type                   res_ff, res_in;

   logic                               accept;
   logic                               req_slot_ok;
   logic [hct_pkg::SLOT_W-1:0]         req_slot_idx;
   logic [hct_pkg::COUNT_W-1:0]        cmp_next;
   logic                               hit;
   logic                               last;
   logic                               full;
   logic                               cid_neg;
   logic                               cid_out;
   logic                               handle_none;
   logic                               clr_done;

   assign accept       = (state_ff == hct_pkg::S_IDLE) && req_valid;
   assign req_slot_ok  = (req.slot != '0) &&
                         ({1'b0, req.slot} <= (hct_pkg::SLOT_IN_W + 1)'(hct_pkg::PROGRAMS));
   assign req_slot_idx = hct_pkg::SLOT_W'(req.slot - hct_pkg::SLOT_IN_W'(1));
   assign cmp_next     = hct_pkg::COUNT_W'(cmp_idx_ff) + hct_pkg::COUNT_W'(1);
   assign hit          = (store_rdata == handle_ff);
   assign last         = (cmp_next == count_ff);
   assign full         = (count_ff == hct_pkg::COUNT_W'(hct_pkg::ENTRIES));
   assign cid_neg      = cid_ff[hct_pkg::ID_W-1];
   assign cid_out      = (cid_ff >= hct_pkg::ID_W'(cnt_rdata)) ||
                         (cid_ff >= hct_pkg::ID_W'(hct_pkg::ENTRIES));
   assign handle_none  = (handle_ff == hct_pkg::HANDLE_NONE);
   assign clr_done     = (clr_idx_ff == hct_pkg::SLOT_W'(hct_pkg::PROGRAMS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hct_pkg::S_CLEAR: begin
            if (clr_done) begin
               state_in = hct_pkg::S_IDLE;
            end
         end
         hct_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = hct_pkg::S_COUNT;
            end
         end
         hct_pkg::S_COUNT: begin
            state_in = hct_pkg::S_RESP;
            case (op_ff)
               hct_pkg::OP_REGISTER: begin
                  if (slot_ok_ff && !handle_none && (cnt_rdata != '0)) begin
                     state_in = hct_pkg::S_SEARCH;
                  end
               end
               hct_pkg::OP_RESOLVE: begin
                  if (!cid_neg && slot_ok_ff && !cid_out) begin
                     state_in = hct_pkg::S_FETCH;
                  end
               end
               default: begin
                  state_in = hct_pkg::S_RESP;
               end
            endcase
         end
         hct_pkg::S_SEARCH: begin
            if (hit || last) begin
               state_in = hct_pkg::S_RESP;
            end
         end
         hct_pkg::S_FETCH: begin
            state_in = hct_pkg::S_RESP;
         end
         hct_pkg::S_RESP: begin
            if (out_free) begin
               state_in = hct_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hct_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready        = 1'b0;
      res_valid        = 1'b0;
      cnt_port.we      = 1'b0;
      cnt_port.waddr   = slot_idx_ff;
      cnt_port.wdata   = '0;
      cnt_port.raddr   = slot_idx_ff;
      store_port.we    = 1'b0;
      store_port.waddr = {slot_idx_ff, count_ff[hct_pkg::ENTRY_W-1:0]};
      store_port.wdata = handle_ff;
      store_port.raddr = {slot_idx_ff, cmp_idx_ff};
      res_in           = res_ff;
      count_in         = count_ff;
      cmp_idx_in       = cmp_idx_ff;
      clr_idx_in       = clr_idx_ff;
      case (state_ff)
         hct_pkg::S_CLEAR: begin
            cnt_port.we    = 1'b1;
            cnt_port.waddr = clr_idx_ff;
            clr_idx_in     = clr_idx_ff + hct_pkg::SLOT_W'(1);
         end
         hct_pkg::S_IDLE: begin
            req_ready      = 1'b1;
            cnt_port.raddr = req_slot_idx;
         end
         hct_pkg::S_COUNT: begin
            count_in         = cnt_rdata;
            cmp_idx_in       = '0;
            store_port.raddr = {slot_idx_ff, {hct_pkg::ENTRY_W{1'b0}}};
            case (op_ff)
               hct_pkg::OP_REGISTER: begin
                  if (!slot_ok_ff) begin
                     res_in = '{hct_pkg::ID_NONE, '0, hct_pkg::STAT_BAD_SLOT};
                  end else if (handle_none) begin
                     res_in = '{hct_pkg::ID_NONE, '0, hct_pkg::STAT_NO_HANDLE};
                  end else if (cnt_rdata == '0) begin
                     // empty list: first entry goes straight in
                     store_port.we    = 1'b1;
                     store_port.waddr = {slot_idx_ff, {hct_pkg::ENTRY_W{1'b0}}};
                     cnt_port.we      = 1'b1;
                     cnt_port.wdata   = hct_pkg::COUNT_W'(1);
                     res_in           = '{'0, '0, hct_pkg::STAT_NEW};
                  end
               end
               hct_pkg::OP_RESOLVE: begin
                  if (cid_neg) begin
                     res_in = '{hct_pkg::ID_NONE, hct_pkg::HANDLE_NONE,
                                hct_pkg::STAT_UNKNOWN};
                  end else if (!slot_ok_ff) begin
                     res_in = '{hct_pkg::ID_NONE, hct_pkg::HANDLE_NONE,
                                hct_pkg::STAT_BAD_SLOT};
                  end else if (cid_out) begin
                     res_in = '{hct_pkg::ID_NONE, hct_pkg::HANDLE_NONE,
                                hct_pkg::STAT_UNKNOWN};
                  end else begin
                     store_port.raddr = {slot_idx_ff, cid_ff[hct_pkg::ENTRY_W-1:0]};
                  end
               end
               hct_pkg::OP_CLEAR: begin
                  if (!slot_ok_ff) begin
                     res_in = '{hct_pkg::ID_NONE, '0, hct_pkg::STAT_BAD_SLOT};
                  end else begin
                     cnt_port.we = 1'b1;
                     res_in      = '{'0, '0, hct_pkg::STAT_NEW};
                  end
               end
               default: begin
                  res_in = '{hct_pkg::ID_NONE, hct_pkg::HANDLE_NONE,
                             hct_pkg::STAT_BAD_SLOT};
               end
            endcase
         end
         hct_pkg::S_SEARCH: begin
            cmp_idx_in       = hct_pkg::ENTRY_W'(cmp_next);
            store_port.raddr = {slot_idx_ff, hct_pkg::ENTRY_W'(cmp_next)};
            if (hit) begin
               res_in = '{hct_pkg::ID_W'(cmp_idx_ff), '0, hct_pkg::STAT_EXISTING};
            end else if (last) begin
               if (full) begin
                  res_in = '{hct_pkg::ID_NONE, '0, hct_pkg::STAT_FULL};
               end else begin
                  store_port.we  = 1'b1;
                  cnt_port.we    = 1'b1;
                  cnt_port.wdata = count_ff + hct_pkg::COUNT_W'(1);
                  res_in         = '{hct_pkg::ID_W'(count_ff), '0, hct_pkg::STAT_NEW};
               end
            end
         end
         hct_pkg::S_FETCH: begin
            res_in = '{cid_ff, store_rdata, hct_pkg::STAT_EXISTING};
         end
         hct_pkg::S_RESP: begin
            res_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hct_pkg::S_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
      if (accept) begin
         op_ff       <= req.opcode;
         slot_ok_ff  <= req_slot_ok;
         slot_idx_ff <= req_slot_idx;
         handle_ff   <= req.handle;
         cid_ff      <= req.cid;
      end
   end

endmodule

>>> hdl/hct_checker.sv
// Port-level checker for the handle compaction table, bound to the top level.
`timescale 1ns / 1ps
`include "handle_compaction_table_assert.svh"

module hct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [hct_pkg::ID_W-1:0]     rsp_result_id,
   input logic signed [hct_pkg::HANDLE_W-1:0] rsp_resolved_handle,
   input logic [hct_pkg::STATUS_W-1:0]        rsp_status
);

   // a stalled result beat holds
   `HCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result_id) && $stable(rsp_resolved_handle) && $stable(rsp_status),
      "stalled result beat changed")

   `HCT_ASSERT_NOW(a_status_range, rsp_valid,
      rsp_status <= hct_pkg::STAT_NO_HANDLE,
      "status code out of range")

   `HCT_ASSERT_NOW(a_bad_slot_id, rsp_valid && (rsp_status == hct_pkg::STAT_BAD_SLOT),
      rsp_result_id == hct_pkg::ID_NONE,
      "bad slot result carries an id")

   `HCT_ASSERT_NOW(a_unknown_id, rsp_valid && (rsp_status == hct_pkg::STAT_UNKNOWN),
      (rsp_resolved_handle == hct_pkg::HANDLE_NONE) && (rsp_result_id == hct_pkg::ID_NONE),
      "unknown id result carries a handle or id")

   `HCT_ASSERT_NOW(a_new_entry, rsp_valid && (rsp_status == hct_pkg::STAT_NEW),
      (rsp_resolved_handle == '0) && !rsp_result_id[hct_pkg::ID_W-1],
      "new entry result malformed")

endmodule

bind handle_compaction_table hct_checker u_hct_checker (.*);
